FILE: hw/rtl/drc_pkg.sv
// ----------------------------------------------------------------------------
// drc_pkg
// Shared types and constants of the dirty rectangle coalescer.
// ----------------------------------------------------------------------------
package drc_pkg;

    // width of an edge coordinate (left/top plus extent) with headroom
    localparam int EDGE_W  = 19;
    // width of an area product of two 17-bit extents
    localparam int AREA_W  = 34;
    // width of the waste sum
    localparam int WASTE_W = 36;

    // merge limit after reset
    localparam logic [31:0] WASTE_RESET = 32'd4096;

    typedef enum logic
    {
        CMD_ADD    = 1'b0,
        CMD_FINISH = 1'b1
    } drc_cmd_t;

    // one input item
    typedef struct packed
    {
        drc_cmd_t           command;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic signed [15:0] rect_w;
        logic signed [15:0] rect_h;
    } drc_in_t;

    // one result item
    typedef struct packed
    {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic [16:0]        out_w;
        logic [16:0]        out_h;
    } drc_out_t;

    // running bounding box
    typedef struct packed
    {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [16:0]        w;
        logic [16:0]        h;
    } drc_rect_t;

    // merge decision handed to the control
    typedef struct packed
    {
        logic      fits;
        drc_rect_t merged;
    } drc_merge_t;

endpackage

FILE: hw/rtl/drc_merge.sv
// ----------------------------------------------------------------------------
// drc_merge
// Union bounds and waste check of a new rectangle against the running box.
// ----------------------------------------------------------------------------
module drc_merge
(
    input  drc_pkg::drc_rect_t  bound,
    input  drc_pkg::drc_in_t    rect,
    input  logic [31:0]         max_waste,
    output drc_pkg::drc_merge_t result
);
    import drc_pkg::*;

    logic signed [EDGE_W-1:0] bx0;
    logic signed [EDGE_W-1:0] bx1;
    logic signed [EDGE_W-1:0] by0;
    logic signed [EDGE_W-1:0] by1;
    logic signed [EDGE_W-1:0] nx0;
    logic signed [EDGE_W-1:0] nx1;
    logic signed [EDGE_W-1:0] ny0;
    logic signed [EDGE_W-1:0] ny1;
    logic signed [EDGE_W-1:0] ux0;
    logic signed [EDGE_W-1:0] ux1;
    logic signed [EDGE_W-1:0] uy0;
    logic signed [EDGE_W-1:0] uy1;
    logic signed [EDGE_W-1:0] uw;
    logic signed [EDGE_W-1:0] uh;
    logic signed [EDGE_W-1:0] iw;
    logic signed [EDGE_W-1:0] ih;
    logic                     inter_hit;
    logic [AREA_W-1:0]        area_u;
    logic [AREA_W-1:0]        area_b;
    logic [AREA_W-1:0]        area_n;
    logic [AREA_W-1:0]        area_i;
    logic [WASTE_W-1:0]       waste;

    // edges of the running box
    assign bx0 = {{(EDGE_W-16){bound.x[15]}}, bound.x};
    assign by0 = {{(EDGE_W-16){bound.y[15]}}, bound.y};
    assign bx1 = bx0 + $signed({{(EDGE_W-17){1'b0}}, bound.w});
    assign by1 = by0 + $signed({{(EDGE_W-17){1'b0}}, bound.h});

    // edges of the new rectangle
    assign nx0 = {{(EDGE_W-16){rect.rect_x[15]}}, rect.rect_x};
    assign ny0 = {{(EDGE_W-16){rect.rect_y[15]}}, rect.rect_y};
    assign nx1 = nx0 + {{(EDGE_W-16){rect.rect_w[15]}}, rect.rect_w};
    assign ny1 = ny0 + {{(EDGE_W-16){rect.rect_h[15]}}, rect.rect_h};

    // union box
    assign ux0 = (bx0 < nx0) ? bx0 : nx0;
    assign uy0 = (by0 < ny0) ? by0 : ny0;
    assign ux1 = (bx1 > nx1) ? bx1 : nx1;
    assign uy1 = (by1 > ny1) ? by1 : ny1;
    assign uw  = ux1 - ux0;
    assign uh  = uy1 - uy0;

    // overlap extents, not positive when disjoint
    assign iw = ((bx1 < nx1) ? bx1 : nx1) - ((bx0 > nx0) ? bx0 : nx0);
    assign ih = ((by1 < ny1) ? by1 : ny1) - ((by0 > ny0) ? by0 : ny0);
    assign inter_hit = (iw > 0) && (ih > 0);

    assign area_u = {{(AREA_W-17){1'b0}}, uw[16:0]} * {{(AREA_W-17){1'b0}}, uh[16:0]};
    assign area_b = {{(AREA_W-17){1'b0}}, bound.w} * {{(AREA_W-17){1'b0}}, bound.h};
    assign area_n = {{(AREA_W-16){1'b0}}, rect.rect_w} * {{(AREA_W-16){1'b0}}, rect.rect_h};
    assign area_i = inter_hit
                  ? {{(AREA_W-17){1'b0}}, iw[16:0]} * {{(AREA_W-17){1'b0}}, ih[16:0]}
                  : '0;

    // never negative, so modular arithmetic gives the exact value
    assign waste = {{(WASTE_W-AREA_W){1'b0}}, area_u}
                 + {{(WASTE_W-AREA_W){1'b0}}, area_i}
                 - {{(WASTE_W-AREA_W){1'b0}}, area_b}
                 - {{(WASTE_W-AREA_W){1'b0}}, area_n};

    assign result.fits     = (waste <= {{(WASTE_W-32){1'b0}}, max_waste});
    assign result.merged.x = ux0[15:0];
    assign result.merged.y = uy0[15:0];
    assign result.merged.w = uw[16:0];
    assign result.merged.h = uh[16:0];

endmodule

FILE: hw/rtl/dirty_rect_coalescer_core.sv
// ----------------------------------------------------------------------------
// dirty_rect_coalescer_core
// Gathers rectangles into a running bounding box and flushes it when a merge
// would waste too many pixels or when a finish command arrives.
// ----------------------------------------------------------------------------
// path: input register, then merge logic into the result register
// throughput: one item per cycle unless a flushing item finds the result stalled;
//   the box update is combinational through the union, four parallel area
//   products (at most 17x17) and the waste compare
// reset: rst_n clears the run flag, both valid flags and reloads the waste
//   limit to 4096; the box registers are loaded by the first valid rectangle
// ----------------------------------------------------------------------------
module dirty_rect_coalescer_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [31:0]       cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  drc_pkg::drc_in_t  in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output drc_pkg::drc_out_t out_item
);
    import drc_pkg::*;

    // merge limit register
    logic [31:0] waste_limit_reg;

    // input stage
    logic    stage_valid_reg;
    drc_in_t stage_item_reg;

    // running box
    logic      run_open_reg;
    logic      run_open_next;
    drc_rect_t bound_reg;
    drc_rect_t bound_next;

    // result register
    logic     out_valid_reg;
    logic     out_valid_next;
    drc_out_t out_item_reg;

    drc_merge_t merge;
    logic       rect_ok;
    logic       produce;
    logic       advance;

    drc_merge u_merge
    (
        .bound     (bound_reg),
        .rect      (stage_item_reg),
        .max_waste (waste_limit_reg),
        .result    (merge)
    );

    // rectangle counts only with positive width and height
    assign rect_ok = !stage_item_reg.rect_w[15] && (stage_item_reg.rect_w != '0)
                  && !stage_item_reg.rect_h[15] && (stage_item_reg.rect_h != '0);

    // decide what the staged item does to the run
    always_comb
    begin
        produce       = 1'b0;
        run_open_next = run_open_reg;
        bound_next    = bound_reg;
        case (stage_item_reg.command)
            CMD_FINISH:
            begin
                produce       = run_open_reg;
                run_open_next = 1'b0;
            end
            CMD_ADD:
            begin
                if (rect_ok)
                begin
                    run_open_next = 1'b1;
                    if (run_open_reg && merge.fits)
                    begin
                        bound_next = merge.merged;
                    end
                    else
                    begin
                        // flush the old box when one is open, start a new run
                        produce      = run_open_reg;
                        bound_next.x = stage_item_reg.rect_x;
                        bound_next.y = stage_item_reg.rect_y;
                        bound_next.w = {1'b0, stage_item_reg.rect_w};
                        bound_next.h = {1'b0, stage_item_reg.rect_h};
                    end
                end
            end
            default:
            begin
                produce = 1'b0;
            end
        endcase
    end

    // staged item retires unless its result finds the output register busy
    assign advance  = stage_valid_reg && (!produce || !out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;

    always_comb
    begin
        if (advance && produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waste_limit_reg <= WASTE_RESET;
            stage_valid_reg <= 1'b0;
            run_open_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                waste_limit_reg <= cfg_wr_data;
            end
            if (in_ready)
            begin
                stage_valid_reg <= in_valid;
            end
            if (advance)
            begin
                run_open_reg <= run_open_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_item_reg <= in_item;
        end
        if (advance)
        begin
            bound_reg <= bound_next;
        end
        if (advance && produce)
        begin
            // result carries the box as it stood before this item
            out_item_reg.out_x <= bound_reg.x;
            out_item_reg.out_y <= bound_reg.y;
            out_item_reg.out_w <= bound_reg.w;
            out_item_reg.out_h <= bound_reg.h;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: hw/rtl/drc_checker.sv
// ----------------------------------------------------------------------------
// drc_checker
// Port level checks of the dirty rectangle coalescer.
// ----------------------------------------------------------------------------
module drc_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input drc_pkg::drc_out_t out_item
);
    import drc_pkg::*;

    // a pending result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a pending result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_item))
        else $error("result changed while stalled");

    // a new result comes from a taken item that passed the input register
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a causing item");

    // input stalls only behind a stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with output free");

endmodule

bind dirty_rect_coalescer_core drc_checker u_drc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
